// File: hdl/cstr_pkg.sv
// Shared types and constants for the count-smaller-to-right block.
`timescale 1ns / 1ps

package cstr_pkg;

   // Width of the per-element count of smaller later elements.
   localparam int CNT_W = 6;

   // Largest count value; counters saturate here.
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Control broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic load;   // an element is being loaded and compared this cycle
      logic shift;  // the head result is taken, every cell pulls from its neighbor
   } cstr_ctrl_type;

endpackage

// File: hdl/cstr_cell.sv
// One storage cell of the chain: a value, its smaller-to-right count and a valid bit.
`timescale 1ns / 1ps

module cstr_cell
   import cstr_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cstr_ctrl_type                 ctrl,
   input  logic signed [VALUE_WIDTH-1:0] in_value,
   input  logic                          prev_valid,
   input  logic                          next_valid,
   input  logic signed [VALUE_WIDTH-1:0] next_value,
   input  logic        [CNT_W-1:0]       next_count,
   output logic                          valid,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic        [CNT_W-1:0]       count
);

   logic                          valid_ff, valid_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic        [CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctrl.shift) begin
         // Drain: take the neighbor's contents, moving toward the head.
         valid_in = next_valid;
         value_in = next_value;
         count_in = next_count;
      end else if (ctrl.load) begin
         if (valid_ff) begin
            if (value_ff > in_value && count_ff != CNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (prev_valid) begin
            // First empty cell of the chain takes the arriving element.
            valid_in = 1'b1;
            value_in = in_value;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign count = count_ff;

endmodule

// File: hdl/count_smaller_to_right_top.sv
// Top level of the count-smaller-to-right block: cell chain and drain control.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_value, req_last_element
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_smaller_count, rsp_last_count, rsp_overflow
//
// While a set is being collected, one element transfer is taken every cycle: every
// cell compares the arriving value with its own in parallel, and the first empty cell
// stores it. The transfer marked last moves the block into draining, where the set of
// n stored elements leaves in n result transfers, one per cycle when rsp_stall is low;
// req_stall stays high for the whole drain. Reset clears only the valid bits and the
// control state, so the block is ready in the first cycle after reset.

module count_smaller_to_right_top
   import cstr_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [CNT_W-1:0]       rsp_smaller_count,
   output logic                          rsp_last_count,
   output logic                          rsp_overflow
);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      dropped_ff, dropped_in;

   cstr_ctrl_type ctrl;

   logic        [MAX_ELEMENTS-1:0] cell_valid;
   logic signed [VALUE_WIDTH-1:0]  cell_value [MAX_ELEMENTS];
   logic        [CNT_W-1:0]        cell_count [MAX_ELEMENTS];

   logic req_accept;
   logic rsp_accept;
   logic store_full;

   // The chain fills from cell 0 upward, so the store is full once the far end holds data.
   assign store_full = cell_valid[MAX_ELEMENTS-1];

   assign req_stall  = (state_ff == ST_DRAIN);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_DRAIN) && cell_valid[0];
   assign rsp_accept = rsp_valid && !rsp_stall;

   // An element that finds the store full is dropped and touches no counter.
   assign ctrl.load  = req_accept && !store_full;
   assign ctrl.shift = rsp_accept;

   // Cell 0 is the head of the chain; it always holds the oldest element.
   assign rsp_smaller_count = cell_count[0];
   assign rsp_last_count    = !cell_valid[1];
   assign rsp_overflow      = dropped_ff;

   genvar g;
   generate
      for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
         logic                          prev_valid;
         logic                          next_valid;
         logic signed [VALUE_WIDTH-1:0] next_value;
         logic        [CNT_W-1:0]       next_count;

         if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_valid = cell_valid[g-1];
         end

         if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = '0;
            assign next_count = '0;
         end else begin : g_link
            assign next_valid = cell_valid[g+1];
            assign next_value = cell_value[g+1];
            assign next_count = cell_count[g+1];
         end

         cstr_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .in_value   (req_value),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .next_value (next_value),
            .next_count (next_count),
            .valid      (cell_valid[g]),
            .value      (cell_value[g]),
            .count      (cell_count[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (store_full) begin
                  dropped_in = 1'b1;
               end
               if (req_last_element) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // The set is done once the final result has been taken.
            if (rsp_accept && rsp_last_count) begin
               state_in   = ST_LOAD;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

// File: hdl/cstr_checker.sv
// Port-level assertions for the count-smaller-to-right block, bound to its top level.
`timescale 1ns / 1ps

module cstr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_element,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_last_count,
   input logic rsp_overflow
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // No element is taken while results of a set are being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during drain");

   // The final element of a set starts the drain in the next cycle.
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_element |=> rsp_valid)
      else $error("set end not followed by results");

   // Results of one set come back to back until the one marked last, all with the same overflow flag.
   a_drain_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_count |=>
         rsp_valid && rsp_overflow == $past(rsp_overflow))
      else $error("drain broken or overflow changed within a set");

   // After the final result the block returns to taking elements.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_count |=> !rsp_valid && !req_stall)
      else $error("drain did not end after final result");

endmodule

bind count_smaller_to_right_top cstr_checker u_cstr_checker (.*);

// File: test/count_smaller_to_right_top_test.sv
// Self-checking testbench for count_smaller_to_right_top.
`timescale 1ns / 1ps

// The testbench feeds sets of signed elements through the request channel. It keeps its own
// copy of the stored set and of the counter beside each element. Every accepted element
// updates that copy. The element marked last turns the stored set into a list of expected
// result transfers. The monitor checks each result transfer field by field against the
// oldest entry of that list.
//
// Stimulus begins with a few hand-picked sets: extreme values, ties, runs in ascending and
// descending order, and a single-element set. It goes on with random sets of random size,
// one of which runs past the 64-entry store. That set drops its surplus elements, its last
// element among them, and shows the overflow flag. Both sides insert random gaps, except
// in a stretch with no gaps on either side.

module count_smaller_to_right_top_test;
   import cstr_pkg::*;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_WIDTH  = 16;
   // The run ends here even if results are still missing.
   localparam int CYCLE_LIMIT  = 100000;
   // Percentage of cycles in which either side idles.
   localparam int GAP_PERCENT  = 26;

   // One element waiting to be sent. When hold is set, the driver keeps the element back
   // until every expected result has arrived.
   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
      logic                          hold;
   } element_type;

   // The fields of one result transfer.
   typedef struct {
      logic [CNT_W-1:0] count;
      logic             last;
      logic             overflow;
   } count_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          req_last_element = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic        [CNT_W-1:0]       rsp_smaller_count;
   logic                          rsp_last_count;
   logic                          rsp_overflow;

   element_type      element_queue[$];
   count_result_type expected_counts[$];

   // These are the testbench's own copy of the stored set.
   logic signed [VALUE_WIDTH-1:0] held_values[MAX_ELEMENTS];
   logic        [CNT_W-1:0]       held_counts[MAX_ELEMENTS];
   int                            held_fill = 0;
   logic                          held_dropped = 1'b0;

   int               mismatches = 0;
   int               items_sent = 0;
   int               results_seen = 0;
   int               cycle_count = 0;
   logic             accepted;
   count_result_type oldest;

   count_smaller_to_right_top #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_smaller_count(rsp_smaller_count),
      .rsp_last_count   (rsp_last_count),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // This task applies one accepted element to the stored set. Every stored value that is
   // strictly greater gains one on its counter, and the counter stops at its maximum. When
   // the store is full, the element is dropped and the set is marked. A last element turns
   // the stored set into expected results in arrival order, then clears the store.
   task automatic tally_smaller_after(input logic signed [VALUE_WIDTH-1:0] value,
                                      input logic last);
      count_result_type r;
      if (held_fill < MAX_ELEMENTS) begin
         for (int i = 0; i < held_fill; i++) begin
            if (held_values[i] > value && held_counts[i] != CNT_MAX)
               held_counts[i] = held_counts[i] + 1'b1;
         end
         held_values[held_fill] = value;
         held_counts[held_fill] = '0;
         held_fill++;
      end else begin
         held_dropped = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < held_fill; i++) begin
            r.count    = held_counts[i];
            r.last     = (i == held_fill - 1);
            r.overflow = held_dropped;
            expected_counts.push_back(r);
         end
         held_fill    = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: result %0d: %s is %0d, expected %0d",
               $time, results_seen, what, got, want);
      mismatches++;
   endtask

   task automatic add_element(input logic signed [VALUE_WIDTH-1:0] value, input logic last,
                              input logic hold);
      element_type e;
      e.value = value;
      e.last  = last;
      e.hold  = hold;
      element_queue.push_back(e);
   endtask

   // The mix gives many ties from a narrow range and many extremes. Full-range draws make
   // every bit take both values.
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      logic signed [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 3))
         0: begin
            v = VALUE_WIDTH'($signed($urandom_range(0, 8)) - 4);
         end
         1: begin
            v = $urandom_range(0, 1) ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                                     : {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         end
         default: begin
            v = VALUE_WIDTH'($urandom);
         end
      endcase
      return v;
   endfunction

   // This is the request driver. The element at the head of the queue is on the port. It
   // leaves the queue when its transfer completes. A new element, or a gap, is set up only
   // when the port is free, so a stalled payload stays put. Gaps are skipped for items 50
   // to 89.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            tally_smaller_after(req_value, req_last_element);
            void'(element_queue.pop_front());
            items_sent++;
         end
         if (!req_valid || accepted) begin
            if (element_queue.size() != 0
                && !(element_queue[0].hold && expected_counts.size() != 0)
                && !((items_sent < 50 || items_sent >= 90)
                     && $urandom_range(0, 99) < GAP_PERCENT)) begin
               req_valid        <= 1'b1;
               req_value        <= element_queue[0].value;
               req_last_element <= element_queue[0].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // This is the result monitor. It checks every completed result transfer against the
   // oldest expectation. After that it picks a random stall for the next cycle, except
   // while results 40 to 89 are received.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               oldest = expected_counts.pop_front();
               if (rsp_smaller_count !== oldest.count)
                  report_mismatch("smaller_count", rsp_smaller_count, oldest.count);
               if (rsp_last_count !== oldest.last)
                  report_mismatch("last_count", rsp_last_count, oldest.last);
               if (rsp_overflow !== oldest.overflow)
                  report_mismatch("overflow", rsp_overflow, oldest.overflow);
            end
         end
         rsp_stall <= (results_seen < 40 || results_seen >= 90)
                      && $urandom_range(0, 99) < GAP_PERCENT;
      end
   end

   // If results are still missing at the cycle limit, the run ends with a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int sent;
      int set_size;
      int set_index;

      // Extremes, zero and minus one. The largest value appears twice, so a tie must
      // not count.
      add_element(16'sd0, 1'b0, 1'b0);
      add_element(16'sh7FFF, 1'b0, 1'b0);
      add_element(16'sh8000, 1'b0, 1'b0);
      add_element(-16'sd1, 1'b0, 1'b0);
      add_element(16'sd1, 1'b0, 1'b0);
      add_element(16'sh7FFF, 1'b1, 1'b0);
      // The set with a single element waits until the first set has drained.
      add_element(16'sh8000, 1'b1, 1'b1);
      // All values are equal.
      add_element(16'sd5, 1'b0, 1'b0);
      add_element(16'sd5, 1'b0, 1'b0);
      add_element(16'sd5, 1'b1, 1'b0);
      // Values fall, so every counter counts all the later elements.
      add_element(16'sd3, 1'b0, 1'b0);
      add_element(16'sd2, 1'b0, 1'b0);
      add_element(16'sd1, 1'b0, 1'b0);
      add_element(16'sd0, 1'b0, 1'b0);
      add_element(-16'sd1, 1'b1, 1'b0);
      // Values rise, so every counter stays at zero.
      add_element(-16'sd5, 1'b0, 1'b0);
      add_element(-16'sd4, 1'b0, 1'b0);
      add_element(-16'sd3, 1'b1, 1'b1);

      // Random sets follow. The fourth set fills the store, then drops two more elements.
      // The last of those two is the last element of the set. Its first element is the
      // largest value, so its counter goes close to the top.
      sent = 0;
      set_index = 0;
      while (sent < 92) begin
         set_size = (set_index == 3) ? MAX_ELEMENTS + 2 : $urandom_range(1, 12);
         for (int i = 0; i < set_size; i++) begin
            add_element((set_index == 3 && i == 0) ? 16'sh7FFF : random_value(),
                        i == set_size - 1,
                        i == 0 && $urandom_range(0, 9) == 0);
         end
         sent += set_size;
         set_index++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (element_queue.size() != 0) @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
      // Waiting on afterwards gives any stray result time to show up.
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/cstr_pkg.sv
hdl/cstr_cell.sv
hdl/count_smaller_to_right_top.sv
hdl/cstr_checker.sv
test/count_smaller_to_right_top_test.sv
